/* hdl/rvs_pkg.sv */
// rvs_pkg: shared constants, request codes and types for the reservoir violation sampler
// no dependencies
package rvs_pkg;
	localparam int NUM_CHECKS_DEF       = 16;
	localparam int SAMPLE_SLOTS_DEF     = 8;
	localparam int VALUES_PER_CHECK_DEF = 4;
	localparam int CFG_IDX_W            = 1;
	localparam int CFG_DATA_W           = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED     = 1'd1;

	localparam logic [1:0] REQ_REPORT = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        level;
		logic [3:0]  check_index;
		logic [31:0] point_id;
		logic [2:0]  slot_index;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [31:0] value_c;
		logic [31:0] value_d;
	} req_t;

	typedef struct packed {
		logic        stored;
		logic [2:0]  stored_slot;
		logic [31:0] violation_count;
		logic        any_standard_failed;
		logic        any_critical_failed;
		logic        slot_valid;
		logic [31:0] read_point_id;
		logic [31:0] read_value_a;
		logic [31:0] read_value_b;
		logic [31:0] read_value_c;
		logic [31:0] read_value_d;
	} rsp_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load_req;
		logic cnt_read;
		logic cnt_write;
		logic clear_all;
		logic rng_step;
		logic div_start;
		logic div_step;
		logic slot_write;
		logic slot_read;
		logic rsp_build;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic [1:0] req_type;
		logic       chk_ok;
		logic       need_draw;
		logic       div_done;
		logic       keep;
	} sts_t;

	function automatic logic [31:0] xorshift32(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction
endpackage

/* hdl/rvs_if.sv */
// rvs_if: valid/ready channel carrying one payload
// depends on nothing; payload type given by parameter
interface rvs_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/rvs_ctrl.sv */
// rvs_ctrl: sequencing state machine for the reservoir violation sampler
// depends on rvs_pkg
module rvs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output rvs_pkg::cmd_t cmd,
	input  rvs_pkg::sts_t sts
);
	import rvs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CNT   = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_MEM   = 3'd4;
	localparam logic [2:0] S_RSP   = 3'd5;
	localparam logic [2:0] S_DRAWN = 3'd6;

	logic [2:0] state_q;
	logic       out_valid_q;

	// output register frees once taken
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load_req = in_valid && in_ready;
			S_CNT:   cmd.cnt_read = 1'b1;
			S_DEC: begin
				if (sts.req_type == REQ_CLEAR) cmd.clear_all = 1'b1;
				else if (sts.req_type == REQ_REPORT && sts.chk_ok) begin
					cmd.cnt_write = 1'b1;
					if (sts.need_draw) begin
						cmd.rng_step  = 1'b1;
						cmd.div_start = 1'b1;
					end
				end
			end
			S_DIV:   cmd.div_step = !sts.div_done;
			S_DRAWN: cmd.slot_write = sts.keep;
			S_MEM:   cmd.slot_read = 1'b1;
			S_RSP:   cmd.rsp_build = 1'b1;
			default: cmd = '0;
		endcase
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:  if (in_valid && in_ready) state_q <= S_CNT;
				S_CNT:   state_q <= S_DEC;
				S_DEC: begin
					if (sts.req_type == REQ_REPORT && sts.chk_ok && sts.need_draw)
						state_q <= S_DIV;
					else if (sts.req_type == REQ_REPORT && sts.chk_ok)
						state_q <= S_DRAWN;
					else
						state_q <= S_MEM;
				end
				S_DIV:   if (sts.div_done) state_q <= S_DRAWN;
				S_DRAWN: state_q <= S_MEM;
				S_MEM:   state_q <= S_RSP;
				S_RSP: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/rvs_datapath.sv */
// rvs_datapath: counters, xorshift generator, serial modulo and sample memories
// depends on rvs_pkg
module rvs_datapath #(
	parameter int NUM_CHECKS       = rvs_pkg::NUM_CHECKS_DEF,
	parameter int SAMPLE_SLOTS     = rvs_pkg::SAMPLE_SLOTS_DEF,
	parameter int VALUES_PER_CHECK = rvs_pkg::VALUES_PER_CHECK_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [rvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rvs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  rvs_pkg::req_t req,
	input  rvs_pkg::cmd_t cmd,
	output rvs_pkg::sts_t sts,
	output rvs_pkg::rsp_t rsp
);
	import rvs_pkg::*;

	localparam int NPAIRS = 2 * NUM_CHECKS;
	localparam int PAIR_W = $clog2(NPAIRS);
	localparam int SLOT_W = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
	localparam int DEPTH  = NPAIRS * (1 << SLOT_W);

	logic [3:0]  k_cfg_q;
	logic [31:0] seed_q;
	logic [31:0] rng_q;
	req_t        req_q;
	logic [31:0] counts_q [NPAIRS];
	logic [31:0] n_q;
	logic [31:0] k_q;
	logic [31:0] rem_q, quo_q, div_n_q;
	logic [5:0]  div_cnt_q;
	logic        div_busy_q;
	logic [31:0] slot_q;
	logic        keep_q;
	logic [31:0] rd_pid_q;
	logic [31:0] rd_val_q [4];
	logic [31:0] pid_mem [DEPTH];
	logic [31:0] val_mem [VALUES_PER_CHECK][DEPTH];

	logic        chk_ok;
	logic [PAIR_W-1:0] pair;
	logic [31:0] n_inc;
	logic [32:0] trial;
	logic [31:0] vals [4];
	logic        any_std, any_crit;
	logic        rd_ok;
	logic [31:0] lim;

	assign chk_ok = {{(32-4){1'b0}}, req_q.check_index} < 32'(NUM_CHECKS);
	// pair row: level block, then check within it
	assign pair   = PAIR_W'(32'(req_q.level) * 32'(NUM_CHECKS)
		+ (chk_ok ? 32'(req_q.check_index) : 32'd0));
	assign n_inc  = (n_q == 32'hFFFF_FFFF) ? n_q : n_q + 32'd1;
	assign vals   = '{req_q.value_a, req_q.value_b, req_q.value_c, req_q.value_d};
	assign trial  = {rem_q, quo_q[31]} - {1'b0, div_n_q};

	// read-back slot is valid below min(count, slots in use)
	assign lim   = (n_q < k_q) ? n_q : k_q;
	assign rd_ok = req_q.req_type == REQ_READ && chk_ok && 32'(req_q.slot_index) < lim;

	assign sts.req_type  = req_q.req_type;
	assign sts.chk_ok    = chk_ok;
	assign sts.need_draw = n_inc > k_q;
	assign sts.div_done  = div_busy_q && div_cnt_q == 6'd32;
	assign sts.keep      = keep_q;

	always_comb begin
		any_std  = 1'b0;
		any_crit = 1'b0;
		for (int i = 0; i < NUM_CHECKS; i++) begin
			any_std  = any_std  | (counts_q[i] != 32'd0);
			any_crit = any_crit | (counts_q[NUM_CHECKS + i] != 32'd0);
		end
	end

	// configuration, counts, generator, serial modulo
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_cfg_q    <= 4'd8;
			seed_q     <= 32'd1;
			rng_q      <= 32'd1;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			for (int i = 0; i < NPAIRS; i++) counts_q[i] <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_SLOTS_IN_USE) k_cfg_q <= cfg_data[3:0];
			if (cfg_we && cfg_index == CFG_RNG_SEED) seed_q <= cfg_data;
			if (cmd.clear_all) begin
				for (int i = 0; i < NPAIRS; i++) counts_q[i] <= '0;
				rng_q <= (seed_q == 32'd0) ? 32'd1 : seed_q;
			end
			if (cmd.cnt_write) counts_q[pair] <= n_inc;
			if (cmd.rng_step) rng_q <= xorshift32(rng_q);
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 6'd1;
			end else if (sts.div_done) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	// request capture and datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q  <= req;
			slot_q <= '0;
			keep_q <= 1'b0;
		end
		if (cmd.cnt_read) begin
			n_q <= chk_ok ? counts_q[pair] : 32'd0;
			if (k_cfg_q == 4'd0) k_q <= 32'd1;
			else if (32'(k_cfg_q) > 32'(SAMPLE_SLOTS)) k_q <= 32'(SAMPLE_SLOTS);
			else k_q <= 32'(k_cfg_q);
		end
		if (cmd.cnt_write) begin
			n_q <= n_inc;
			if (!sts.need_draw) begin
				slot_q <= n_inc - 32'd1;
				keep_q <= 1'b1;
			end
		end
		if (cmd.div_start) begin
			quo_q   <= xorshift32(rng_q);
			rem_q   <= '0;
			div_n_q <= n_inc;
		end else if (cmd.div_step) begin
			// restoring division, one bit a cycle
			if (!trial[32]) rem_q <= trial[31:0];
			else rem_q <= {rem_q[30:0], quo_q[31]};
			quo_q <= {quo_q[30:0], 1'b0};
		end else if (sts.div_done && div_busy_q) begin
			slot_q <= rem_q;
			keep_q <= rem_q < k_q;
		end
	end

	// sample memories
	always_ff @(posedge clk) begin
		if (cmd.slot_write) begin
			pid_mem[{pair, SLOT_W'(slot_q)}] <= req_q.point_id;
			for (int j = 0; j < VALUES_PER_CHECK; j++)
				val_mem[j][{pair, SLOT_W'(slot_q)}] <= vals[j];
		end
		if (cmd.slot_read) begin
			rd_pid_q <= pid_mem[{pair, SLOT_W'(req_q.slot_index)}];
			for (int j = 0; j < 4; j++)
				rd_val_q[j] <= (j < VALUES_PER_CHECK) ?
					val_mem[(j < VALUES_PER_CHECK) ? j : 0][{pair, SLOT_W'(req_q.slot_index)}]
					: 32'd0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.rsp_build) begin
			rsp.stored              <= keep_q;
			rsp.stored_slot         <= keep_q ? slot_q[2:0] : 3'd0;
			rsp.violation_count     <= (chk_ok && req_q.req_type != REQ_CLEAR) ? n_q : 32'd0;
			rsp.any_standard_failed <= any_std;
			rsp.any_critical_failed <= any_crit;
			rsp.slot_valid          <= rd_ok;
			rsp.read_point_id       <= rd_ok ? rd_pid_q : 32'd0;
			rsp.read_value_a        <= rd_ok ? rd_val_q[0] : 32'd0;
			rsp.read_value_b        <= rd_ok ? rd_val_q[1] : 32'd0;
			rsp.read_value_c        <= rd_ok ? rd_val_q[2] : 32'd0;
			rsp.read_value_d        <= rd_ok ? rd_val_q[3] : 32'd0;
		end
	end
endmodule

/* hdl/reservoir_violation_sampler_top.sv */
// Reservoir violation sampler. A read, clear or unknown request passes the count, decode, memory
// and response states; a report that fills a free slot also passes the slot-write state, and one
// that must draw a random slot (count above the slots in use) also waits on the 32-step bit-serial
// modulo of the xorshift value by the running count. One request is in flight at a time; the next is
// accepted once the result is taken, at the earliest in the same cycle.
// top level; depends on rvs_pkg, rvs_if, rvs_ctrl, rvs_datapath
module reservoir_violation_sampler_top #(
	parameter int NUM_CHECKS       = rvs_pkg::NUM_CHECKS_DEF,
	parameter int SAMPLE_SLOTS     = rvs_pkg::SAMPLE_SLOTS_DEF,
	parameter int VALUES_PER_CHECK = rvs_pkg::VALUES_PER_CHECK_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rvs_pkg::CFG_DATA_W-1:0] cfg_data,
	rvs_if.sink   req,
	rvs_if.source rsp
);
	import rvs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rvs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd), .sts(sts)
	);

	rvs_datapath #(
		.NUM_CHECKS(NUM_CHECKS), .SAMPLE_SLOTS(SAMPLE_SLOTS),
		.VALUES_PER_CHECK(VALUES_PER_CHECK)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req(req.data), .cmd(cmd), .sts(sts), .rsp(rsp.data)
	);
endmodule

/* hdl/rvs_checker.sv */
// rvs_checker: port-level assertions for the reservoir violation sampler
// depends on rvs_pkg; bound to reservoir_violation_sampler_top
module rvs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic stored,
	input logic [2:0] stored_slot,
	input logic slot_valid,
	input logic [31:0] read_point_id
);
	import rvs_pkg::*;

	// a result appears only after an accepted request
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");
	// one request in flight: no acceptance next cycle
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second accept");
	// stall holds result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	// store and read are exclusive
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(stored && slot_valid)) else $error("store and read both");
	// fields of an absent store or read are zero
	a_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((stored || stored_slot == 3'd0) &&
		(slot_valid || read_point_id == 32'd0))) else $error("stray field");
endmodule

bind reservoir_violation_sampler_top rvs_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.stored(rsp.data.stored), .stored_slot(rsp.data.stored_slot),
	.slot_valid(rsp.data.slot_valid), .read_point_id(rsp.data.read_point_id)
);
